### sv/sgcdu_pkg.sv
// ----------------------------------------------------------------------------
// sgcdu_pkg
// shared constants and types for the semigroup child delta update block
// ----------------------------------------------------------------------------
package sgcdu_pkg;

    localparam int SIZE_DEF = 256;
    localparam int LANES    = 16;
    localparam int LANE_W   = 4;
    localparam int CNT_W    = 8;
    localparam int ROW_W    = LANES * CNT_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SON  = 1'b1;

    typedef logic [ROW_W-1:0] t_row;

    typedef enum logic [2:0] {
        S_LOAD,
        S_IDLE,
        S_PRO,
        S_FETCH,
        S_SWEEP,
        S_DONE
    } t_state;

endpackage

### sv/semigroup_child_delta_update.sv
// ----------------------------------------------------------------------------
// semigroup_child_delta_update
// decomposition-count array of one numerical semigroup, updated row by row
// load writes all rows; son sweeps last row down to row generator/16; refused son skips both
// ROWS = ceil(SIZE/16): one 16-count row of the count memory per cycle
// one beat at a time; a new beat is taken while the last result waits in the output register
// after reset the naturals are written row by row with the input stalled
// ----------------------------------------------------------------------------
module semigroup_child_delta_update
    import sgcdu_pkg::*;
#(
    parameter int SIZE = SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_generator,
    input  logic [7:0]  i_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [8:0]  o_conductor,
    output logic [7:0]  o_genus,
    output logic [8:0]  o_multiplicity,
    output logic [8:0]  o_embedding_dim,
    output logic [15:0] o_left_gen_sum,
    output logic [15:0] o_left_elements,
    output logic        o_bad
);

    localparam int ROWS = (SIZE + LANES - 1) / LANES;
    localparam int RAW  = $clog2(ROWS);
    localparam int IW   = LANE_W + 1;
    localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);
    localparam logic [10:0]    SIZE_V   = 11'(SIZE);

    t_row mem [ROWS];
    t_row r_rd_a;
    t_row r_rd_b;
    logic           mem_we;
    t_row           mem_wdata;
    logic [RAW-1:0] addr_a;
    logic [RAW-1:0] addr_b;

    t_state r_state, n_state;
    logic [RAW-1:0] r_row, n_row;
    logic           r_from_op, n_from_op;
    logic [7:0]     r_x, n_x;
    logic [7:0]     r_pos, n_pos;
    logic           r_bad, n_bad;
    t_row           r_held, n_held;
    logic [8:0]     r_cond, n_cond;
    logic [7:0]     r_genus, n_genus;
    logic [8:0]     r_mult, n_mult;
    logic [8:0]     r_emb, n_emb;
    logic [15:0]    r_lgs, n_lgs;
    logic [15:0]    r_lel, n_lel;

    logic           r_out_valid, n_out_valid;
    logic [8:0]     r_out_cond, n_out_cond;
    logic [7:0]     r_out_genus, n_out_genus;
    logic [8:0]     r_out_mult, n_out_mult;
    logic [8:0]     r_out_emb, n_out_emb;
    logic [15:0]    r_out_lgs, n_out_lgs;
    logic [15:0]    r_out_lel, n_out_lel;
    logic           r_out_bad, n_out_bad;

    logic [RAW-1:0]    k_row;
    logic [LANE_W-1:0] xl;
    logic [9:0]        sum;
    logic [RAW-1:0]    sum_row;
    logic [LANE_W-1:0] sum_lane;
    logic [9:0]        in_sum;
    logic              in_bad;
    logic [RAW-1:0]    rd_dest;
    logic [RAW-1:0]    rd_src;
    logic [CNT_W-1:0]  probe;
    t_row              load_row;
    t_row              sweep_row;

    assign k_row    = RAW'(r_x >> LANE_W);
    assign xl       = r_x[LANE_W-1:0];
    assign sum      = {2'b00, r_x} + {1'b0, r_mult};
    assign sum_row  = RAW'(sum >> LANE_W);
    assign sum_lane = sum[LANE_W-1:0];
    assign in_sum   = {2'b00, i_generator} + {1'b0, r_mult};
    assign in_bad   = ({1'b0, i_generator} < r_cond) || ({1'b0, in_sum} >= SIZE_V);
    assign probe    = r_rd_a[sum_lane*CNT_W +: CNT_W];

    assign rd_dest = (r_state == S_SWEEP && r_row != '0) ? r_row - RAW'(1) : r_row;
    assign rd_src  = (rd_dest == k_row) ? '0 : rd_dest - k_row - RAW'(1);

    // count memory, one row of lanes per entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_row] <= mem_wdata;
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    // naturals: count 1 + i/2 at index i
    always_comb begin
        logic [RAW+LANE_W-1:0] ent;
        ent = '0;
        for (int j = 0; j < LANES; j++) begin
            ent = {r_row, LANE_W'(j)};
            load_row[j*CNT_W +: CNT_W] = CNT_W'(ent >> 1) + CNT_W'(1);
        end
    end

    // shift-subtract over one row: parent count at y-x gates the decrement at y
    always_comb begin
        logic [2*ROW_W-1:0] cat;
        logic [IW-1:0]      idx;
        logic [CNT_W-1:0]   src;
        logic [CNT_W-1:0]   cur;
        logic               active;
        cat    = {r_held, r_rd_b};
        idx    = '0;
        src    = '0;
        cur    = '0;
        active = 1'b0;
        for (int j = 0; j < LANES; j++) begin
            idx    = IW'(j + LANES) - {1'b0, xl};
            src    = cat[idx*CNT_W +: CNT_W];
            cur    = r_rd_a[j*CNT_W +: CNT_W];
            active = (r_row != k_row) || (LANE_W'(j) >= xl);
            sweep_row[j*CNT_W +: CNT_W] = (active && src != '0) ? cur - CNT_W'(1) : cur;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_from_op   = r_from_op;
        n_x         = r_x;
        n_pos       = r_pos;
        n_bad       = r_bad;
        n_held      = r_held;
        n_cond      = r_cond;
        n_genus     = r_genus;
        n_mult      = r_mult;
        n_emb       = r_emb;
        n_lgs       = r_lgs;
        n_lel       = r_lel;
        n_out_valid = r_out_valid;
        n_out_cond  = r_out_cond;
        n_out_genus = r_out_genus;
        n_out_mult  = r_out_mult;
        n_out_emb   = r_out_emb;
        n_out_lgs   = r_out_lgs;
        n_out_lel   = r_out_lel;
        n_out_bad   = r_out_bad;
        mem_we      = 1'b0;
        mem_wdata   = load_row;
        addr_a      = rd_dest;
        addr_b      = rd_src;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                mem_we = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_state = r_from_op ? S_DONE : S_IDLE;
                end else begin
                    n_row = r_row + RAW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_x   = i_generator;
                    n_pos = i_position;
                    if (i_op == OP_LOAD) begin
                        n_row     = '0;
                        n_from_op = 1'b1;
                        n_bad     = 1'b0;
                        n_cond    = 9'd1;
                        n_genus   = 8'd0;
                        n_mult    = 9'd1;
                        n_emb     = 9'd1;
                        n_lgs     = 16'd0;
                        n_lel     = 16'd1;
                        n_state   = S_LOAD;
                    end else if (in_bad) begin
                        n_bad   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_bad   = 1'b0;
                        n_state = S_PRO;
                    end
                end
            end
            S_PRO: begin
                addr_a  = sum_row;
                addr_b  = LAST_ROW - k_row;
                n_row   = LAST_ROW;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_held = r_rd_b;
                if ({1'b0, r_x} > r_mult) begin
                    if (probe != CNT_W'(2)) begin
                        n_emb = r_emb - 9'd1;
                    end
                end else begin
                    n_mult = r_mult + 9'd1;
                    n_emb  = r_emb + 9'd1;
                end
                n_lel   = r_lel + 16'(r_x) - 16'(r_cond);
                n_lgs   = r_lgs + 16'(r_pos);
                n_cond  = {1'b0, r_x} + 9'd1;
                n_genus = r_genus + 8'd1;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_wdata = sweep_row;
                n_held    = r_rd_b;
                if (r_row == k_row) begin
                    n_state = S_DONE;
                end else begin
                    n_row = r_row - RAW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_cond  = r_cond;
                    n_out_genus = r_genus;
                    n_out_mult  = r_mult;
                    n_out_emb   = r_emb;
                    n_out_lgs   = r_lgs;
                    n_out_lel   = r_lel;
                    n_out_bad   = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_from_op   <= 1'b0;
            r_cond      <= 9'd1;
            r_genus     <= 8'd0;
            r_mult      <= 9'd1;
            r_emb       <= 9'd1;
            r_lgs       <= 16'd0;
            r_lel       <= 16'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_row       <= n_row;
            r_from_op   <= n_from_op;
            r_cond      <= n_cond;
            r_genus     <= n_genus;
            r_mult      <= n_mult;
            r_emb       <= n_emb;
            r_lgs       <= n_lgs;
            r_lel       <= n_lel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_pos       <= n_pos;
        r_bad       <= n_bad;
        r_held      <= n_held;
        r_out_cond  <= n_out_cond;
        r_out_genus <= n_out_genus;
        r_out_mult  <= n_out_mult;
        r_out_emb   <= n_out_emb;
        r_out_lgs   <= n_out_lgs;
        r_out_lel   <= n_out_lel;
        r_out_bad   <= n_out_bad;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_conductor     = r_out_cond;
    assign o_genus         = r_out_genus;
    assign o_multiplicity  = r_out_mult;
    assign o_embedding_dim = r_out_emb;
    assign o_left_gen_sum  = r_out_lgs;
    assign o_left_elements = r_out_lel;
    assign o_bad           = r_out_bad;

endmodule

### sv/sgcdu_checker.sv
// ----------------------------------------------------------------------------
// sgcdu_checker
// port-level checks for the semigroup child delta update block
// ----------------------------------------------------------------------------
module sgcdu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_op,
    input logic [7:0]  i_generator,
    input logic [7:0]  i_position,
    input logic        o_valid,
    input logic        i_stall,
    input logic [8:0]  o_conductor,
    input logic [7:0]  o_genus,
    input logic [8:0]  o_multiplicity,
    input logic [8:0]  o_embedding_dim,
    input logic [15:0] o_left_gen_sum,
    input logic [15:0] o_left_elements,
    input logic        o_bad
);

    // load pass of the naturals follows reset
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled after reset");

    // one beat at a time
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after a beat");

    // multiplicity never passes the conductor
    a_mult_le_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_multiplicity <= o_conductor)
        else $error("multiplicity above conductor");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_conductor) && $stable(o_genus)
            && $stable(o_embedding_dim) && $stable(o_left_gen_sum)
            && $stable(o_left_elements) && $stable(o_bad))
        else $error("stalled result beat changed");

endmodule

bind semigroup_child_delta_update sgcdu_checker u_sgcdu_checker (.*);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for semigroup_child_delta_update. A clocked driver
// sends load and son beats from a plan queue. Son generators are picked
// against the bench's own copy of the count array. Most walks follow real
// minimal generators down the tree. The rest are refused or random beats.
// A clocked monitor checks every result field by field against the oldest
// predicted scalar set. Both sides idle at random. The receiver holds off
// for one long stretch, and the sender drains once.
// ----------------------------------------------------------------------------
module tb_top;
    import sgcdu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 6;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_BEATS = 600;
    localparam int LONG_HOLD_AT = 200;
    localparam int LONG_HOLD    = 500;

    typedef enum {
        B_FIXED,
        B_GROW,
        B_LOW,
        B_HIGH,
        B_NOISE,
        B_DRAIN
    } t_beat_kind;

    typedef struct {
        t_beat_kind kind;
        logic       op;
        logic [7:0] generator;
        logic [7:0] position;
    } t_beat;

    typedef struct {
        logic [8:0]  conductor;
        logic [7:0]  genus;
        logic [8:0]  multiplicity;
        logic [8:0]  embedding_dim;
        logic [15:0] left_gen_sum;
        logic [15:0] left_elements;
        logic        bad;
    } t_scalars;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_op        = OP_LOAD;
    logic [7:0]  i_generator = '0;
    logic [7:0]  i_position  = '0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [8:0]  o_conductor;
    logic [7:0]  o_genus;
    logic [8:0]  o_multiplicity;
    logic [8:0]  o_embedding_dim;
    logic [15:0] o_left_gen_sum;
    logic [15:0] o_left_elements;
    logic        o_bad;

    t_beat       beat_plan [$];
    t_scalars    want_scalars [$];
    int unsigned n_fail   = 0;
    int unsigned n_cycles = 0;
    int unsigned n_sent   = 0;
    int unsigned n_got    = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;

    logic [7:0]  sg_counts [SIZE_DEF];
    logic [8:0]  sg_conductor;
    logic [7:0]  sg_genus;
    logic [8:0]  sg_multiplicity;
    logic [8:0]  sg_embedding;
    logic [15:0] sg_left_gen_sum;
    logic [15:0] sg_left_elements;

    semigroup_child_delta_update i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_generator     (i_generator),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_conductor     (o_conductor),
        .o_genus         (o_genus),
        .o_multiplicity  (o_multiplicity),
        .o_embedding_dim (o_embedding_dim),
        .o_left_gen_sum  (o_left_gen_sum),
        .o_left_elements (o_left_elements),
        .o_bad           (o_bad)
    );

    always #1 i_clk = ~i_clk;

    function automatic void load_naturals();
        for (int i = 0; i < SIZE_DEF; i++) begin
            sg_counts[i] = 8'(1 + i / 2);
        end
        sg_conductor     = 9'd1;
        sg_genus         = 8'd0;
        sg_multiplicity  = 9'd1;
        sg_embedding     = 9'd1;
        sg_left_gen_sum  = 16'd0;
        sg_left_elements = 16'd1;
    endfunction

    function automatic t_scalars semigroup_step(logic op, logic [7:0] x, logic [7:0] pos);
        logic [7:0] parent [SIZE_DEF];
        t_scalars   r;
        int         xi;
        int         mi;
        r.bad = 1'b0;
        xi = int'(x);
        mi = int'(sg_multiplicity);
        if (op == OP_LOAD) begin
            load_naturals();
        end else if (xi < int'(sg_conductor) || xi + mi >= SIZE_DEF) begin
            r.bad = 1'b1;
        end else begin
            parent = sg_counts;
            if (xi > mi) begin
                if (parent[xi + mi] != 8'd2) sg_embedding = sg_embedding - 9'd1;
            end else begin
                sg_multiplicity = sg_multiplicity + 9'd1;
                sg_embedding    = sg_embedding + 9'd1;
            end
            sg_left_elements = sg_left_elements + 16'(x) - 16'(sg_conductor);
            sg_left_gen_sum  = sg_left_gen_sum + 16'(pos);
            sg_conductor     = 9'(x) + 9'd1;
            sg_genus         = sg_genus + 8'd1;
            for (int y = xi; y < SIZE_DEF; y++) begin
                if (parent[y - xi] != 8'd0) sg_counts[y] = sg_counts[y] - 8'd1;
            end
        end
        r.conductor     = sg_conductor;
        r.genus         = sg_genus;
        r.multiplicity  = sg_multiplicity;
        r.embedding_dim = sg_embedding;
        r.left_gen_sum  = sg_left_gen_sum;
        r.left_elements = sg_left_elements;
        return r;
    endfunction

    // fill in op and fields from the current semigroup
    function automatic t_beat settle_beat(t_beat b);
        t_beat r;
        int    lo;
        int    hi;
        int    n;
        int    cand [$];
        r = b;
        lo = int'(sg_conductor);
        hi = SIZE_DEF - 1 - int'(sg_multiplicity);
        case (b.kind)
            B_GROW: begin
                if (lo > hi) begin
                    r.op        = OP_LOAD;
                    r.generator = 8'($urandom_range(0, 255));
                    r.position  = 8'($urandom_range(0, 255));
                end else begin
                    r.op = OP_SON;
                    for (int y = lo; y <= hi; y++) begin
                        if (sg_counts[y] == 8'd1) cand.push_back(y);
                    end
                    if (cand.size() > 0 && $urandom_range(0, 7) != 0) begin
                        n = $urandom_range(0, cand.size() - 1);
                        r.generator = 8'(cand[n]);
                        r.position  = 8'(n);
                    end else begin
                        r.generator = 8'($urandom_range(lo, hi));
                        r.position  = 8'($urandom_range(0, 255));
                    end
                end
            end
            B_LOW: begin
                r.op        = OP_SON;
                r.generator = 8'($urandom_range(0, lo - 1));
                r.position  = 8'($urandom_range(0, 255));
            end
            B_HIGH: begin
                r.op = OP_SON;
                if (SIZE_DEF - int'(sg_multiplicity) > lo) lo = SIZE_DEF - int'(sg_multiplicity);
                if (lo > 255) lo = 255;
                r.generator = 8'($urandom_range(lo, 255));
                r.position  = 8'($urandom_range(0, 255));
            end
            B_NOISE: begin
                r.op        = logic'($urandom_range(0, 1));
                r.generator = 8'($urandom_range(0, 255));
                r.position  = 8'($urandom_range(0, 255));
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // every fourth stretch of 60 beats runs without idling
    function automatic int unsigned idle_draw(int unsigned n);
        if ((n / 60) % 4 == 3) return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic void add_fixed(logic op, logic [7:0] g, logic [7:0] p);
        beat_plan.push_back('{B_FIXED, op, g, p});
    endfunction

    function automatic void add_kind(t_beat_kind k);
        beat_plan.push_back('{k, OP_LOAD, 8'd0, 8'd0});
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t %s expected %0d actual %0d", $realtime, name, want, got);
            n_fail++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_beat b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
            load_naturals();
        end else begin
            if (i_valid && !o_stall) begin
                want_scalars.push_back(semigroup_step(i_op, i_generator, i_position));
                n_sent++;
                gap_left = idle_draw(n_sent);
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (beat_plan.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (beat_plan[0].kind == B_DRAIN) begin
                    i_valid <= 1'b0;
                    if (want_scalars.size() == 0) void'(beat_plan.pop_front());
                end else begin
                    b = settle_beat(beat_plan.pop_front());
                    i_op        <= b.op;
                    i_generator <= b.generator;
                    i_position  <= b.position;
                    i_valid     <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_scalars w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (want_scalars.size() == 0) begin
                    $display("%0t unexpected beat conductor %0d genus %0d",
                             $realtime, o_conductor, o_genus);
                    n_fail++;
                end else begin
                    w = want_scalars.pop_front();
                    check_field("conductor", w.conductor, o_conductor);
                    check_field("genus", w.genus, o_genus);
                    check_field("multiplicity", w.multiplicity, o_multiplicity);
                    check_field("embedding_dim", w.embedding_dim, o_embedding_dim);
                    check_field("left_gen_sum", w.left_gen_sum, o_left_gen_sum);
                    check_field("left_elements", w.left_elements, o_left_elements);
                    check_field("bad", w.bad, o_bad);
                end
                n_got++;
                hold_left = (n_got == LONG_HOLD_AT) ? LONG_HOLD : idle_draw(n_got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned len;
        int unsigned r;
        bit          drained;

        // directed walk from the naturals
        add_fixed(OP_LOAD, 8'd0, 8'd0);
        add_fixed(OP_SON, 8'd0, 8'd0);
        add_fixed(OP_SON, 8'd255, 8'd255);
        add_fixed(OP_LOAD, 8'd255, 8'd255);
        add_fixed(OP_SON, 8'd1, 8'd0);
        add_fixed(OP_SON, 8'd2, 8'd255);
        add_fixed(OP_SON, 8'd3, 8'd0);
        add_fixed(OP_SON, 8'd5, 8'd1);
        add_fixed(OP_SON, 8'd4, 8'd0);
        add_kind(B_GROW);
        add_kind(B_GROW);
        add_kind(B_LOW);
        add_kind(B_HIGH);
        add_kind(B_GROW);
        add_fixed(OP_LOAD, 8'd170, 8'd85);
        add_fixed(OP_SON, 8'd1, 8'd128);
        add_fixed(OP_SON, 8'd254, 8'd1);
        add_fixed(OP_SON, 8'd253, 8'd255);
        add_kind(B_GROW);
        add_kind(B_GROW);
        add_kind(B_NOISE);

        n = 0;
        drained = 1'b0;
        while (n < RANDOM_BEATS) begin
            add_fixed(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            n++;
            len = $urandom_range(1, 45);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 84) add_kind(B_GROW);
                else if (r < 89) add_kind(B_LOW);
                else if (r < 94) add_kind(B_HIGH);
                else add_kind(B_NOISE);
                n++;
            end
            if (!drained && n >= RANDOM_BEATS / 2) begin
                add_kind(B_DRAIN);
                drained = 1'b1;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beat_plan.size() > 0 || i_valid || want_scalars.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_fail == 0 && want_scalars.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
sv/sgcdu_pkg.sv
sv/semigroup_child_delta_update.sv
sv/sgcdu_checker.sv
bench/tb_top.sv
